>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/rlee_pkg.sv
// Package for the RGB LED effect engine: request and mode codes, defaults,
// and the constant function that builds the breathing wave table.
`timescale 1ns / 1ps
package rlee_pkg;

  localparam int SineTableBitsDef = 8;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_STATIC = 3'd1;
  localparam logic [2:0] REQ_FADE   = 3'd2;
  localparam logic [2:0] REQ_BLINK  = 3'd3;
  localparam logic [2:0] REQ_SINE   = 3'd4;
  localparam logic [2:0] REQ_OFF    = 3'd5;

  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_STATIC = 3'd1;
  localparam logic [2:0] MODE_FADE   = 3'd2;
  localparam logic [2:0] MODE_BLINK  = 3'd3;
  localparam logic [2:0] MODE_SINE   = 3'd4;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef logic [7:0] level_t;

  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint signed   sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  function automatic level_t wave_value(input int i, input int bits);
    int unsigned     quarter;
    int unsigned     q;
    int unsigned     r;
    int unsigned     p;
    longint unsigned theta;
    longint unsigned m;
    longint unsigned v;
    quarter = 1 << (bits - 2);
    q = i >> (bits - 2);
    r = i & (quarter - 1);
    p = ((q & 1) != 0) ? (quarter - r) : r;
    theta = (longint'(p) * HalfPiQ30) >> (bits - 2);
    m = (sin_q30(theta) + (64'd1 << 22)) >> 23;
    if (q >= 2) v = (m >= 128) ? 64'd0 : (64'd128 - m);
    else v = 64'd128 + m;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic level_t chan(input logic [23:0] c, input logic [1:0] ch);
    case (ch)
      2'd0: return c[23:16];
      2'd1: return c[15:8];
      default: return c[7:0];
    endcase
  endfunction

endpackage

>>> hw/rtl/rgb_led_effect_engine.sv
// RGB LED effect engine, single module: mode state, tick sequencer, shared
// serial divider and wave table. Depends on rlee_pkg and assert_macros.svh.
//
// Command transfers (static, fade, blink, sine, off) give no result. A tick
// transfer advances the millisecond counter and gives one colour, except in
// static mode. Off and blink ticks go from evaluation to output; sine ticks
// add a phase multiply, then table and channel scaling; a fade tick past its
// span gives the target colour, else each channel takes a multiply step and
// eight bits of the shared one-bit-per-cycle divider. Input stall stays high
// from a tick transfer until its result is taken, or evaluated if static.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgb_led_effect_engine import rlee_pkg::*; #(
  parameter int SINE_TABLE_BITS = SineTableBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [31:0] in_span_ms,
  input  logic [31:0] in_sine_rate,
  input  logic [7:0]  in_step_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out
);

  localparam int TableDepth = 1 << SINE_TABLE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SINE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r;
  logic [2:0]  mode_r;
  logic [31:0] time_r;
  logic [23:0] cur_r, from_r, to_r, bcol_r, scol_r;
  logic [31:0] len_r, fbeg_r, bper_r, blast_r, srate_r, sbeg_r;
  logic        blit_r;
  logic [1:0]  ch_r;
  logic [2:0]  cnt_r;
  logic [31:0] rem_r;
  logic [7:0]  low_r;
  logic [7:0]  quo_r;
  logic [31:0] elapsed_r;
  logic [31:0] phase_r;
  logic [7:0]  red_r, green_r, blue_r;

  level_t wave_rom [TableDepth];
  for (genvar gi = 0; gi < TableDepth; gi++) begin : g_rom
    assign wave_rom[gi] = wave_value(gi, SINE_TABLE_BITS);
  end

  logic        accept;
  logic [23:0] in_col;
  logic [31:0] e_fade;
  logic [31:0] e_blink;
  level_t      ch_from, ch_to, delta;
  logic [39:0] prod;
  logic [32:0] trial;
  logic        qbit;
  logic [31:0] rem_nxt;
  logic [7:0]  quo_nxt;
  level_t      fade_val;
  level_t      f_lvl;
  logic [15:0] sr, sg, sb;

  assign accept  = in_valid && !in_stall;
  assign in_col  = {in_red_in, in_green_in, in_blue_in};
  assign e_fade  = time_r - fbeg_r;
  assign e_blink = time_r - blast_r;
  assign ch_from = chan(from_r, ch_r);
  assign ch_to   = chan(to_r, ch_r);
  assign delta   = (ch_to >= ch_from) ? (ch_to - ch_from) : (ch_from - ch_to);
  assign prod    = {32'd0, delta} * {8'd0, elapsed_r};
  assign trial   = {rem_r, low_r[7]};
  assign qbit    = trial >= {1'b0, len_r};
  assign rem_nxt = qbit ? 32'(trial - {1'b0, len_r}) : trial[31:0];
  assign quo_nxt = {quo_r[6:0], qbit};
  assign fade_val = (ch_to >= ch_from) ? (ch_from + quo_nxt) : (ch_from - quo_nxt);
  assign f_lvl   = wave_rom[phase_r[31 -: SINE_TABLE_BITS]];
  assign sr      = scol_r[23:16] * f_lvl;
  assign sg      = scol_r[15:8] * f_lvl;
  assign sb      = scol_r[7:0] * f_lvl;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= MODE_OFF;
      time_r <= '0;
      cur_r <= '0;
      from_r <= '0;
      to_r <= '0;
      len_r <= '0;
      fbeg_r <= '0;
      bcol_r <= '0;
      bper_r <= '0;
      blit_r <= 1'b0;
      blast_r <= '0;
      scol_r <= '0;
      srate_r <= '0;
      sbeg_r <= '0;
      ch_r <= '0;
      cnt_r <= '0;
      rem_r <= '0;
      low_r <= '0;
      quo_r <= '0;
      elapsed_r <= '0;
      phase_r <= '0;
      red_r <= '0;
      green_r <= '0;
      blue_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_req_type)
              REQ_TICK: begin
                time_r <= time_r + {24'd0, in_step_ms};
                state_r <= S_EVAL;
              end
              REQ_STATIC: begin
                mode_r <= MODE_STATIC;
                cur_r <= in_col;
              end
              REQ_FADE: begin
                mode_r <= MODE_FADE;
                from_r <= cur_r;
                to_r <= in_col;
                len_r <= in_span_ms;
                fbeg_r <= time_r;
              end
              REQ_BLINK: begin
                mode_r <= MODE_BLINK;
                bcol_r <= in_col;
                bper_r <= in_span_ms;
                blit_r <= 1'b0;
                blast_r <= time_r;
              end
              REQ_SINE: begin
                mode_r <= MODE_SINE;
                scol_r <= in_col;
                srate_r <= in_sine_rate;
                sbeg_r <= time_r;
              end
              REQ_OFF: begin
                mode_r <= MODE_OFF;
                cur_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_EVAL: begin
          case (mode_r)
            MODE_OFF: begin
              {red_r, green_r, blue_r} <= '0;
              state_r <= S_OUT;
            end
            MODE_FADE: begin
              if (e_fade >= len_r) begin
                cur_r <= to_r;
                mode_r <= MODE_STATIC;
                {red_r, green_r, blue_r} <= to_r;
                state_r <= S_OUT;
              end else begin
                elapsed_r <= e_fade;
                ch_r <= '0;
                state_r <= S_MUL;
              end
            end
            MODE_BLINK: begin
              if (e_blink >= bper_r) begin
                blit_r <= !blit_r;
                blast_r <= time_r;
                {red_r, green_r, blue_r} <= blit_r ? 24'd0 : bcol_r;
              end else begin
                {red_r, green_r, blue_r} <= blit_r ? bcol_r : 24'd0;
              end
              state_r <= S_OUT;
            end
            MODE_SINE: begin
              phase_r <= 32'((time_r - sbeg_r) * srate_r);
              state_r <= S_SINE;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_MUL: begin
          rem_r <= prod[39:8];
          low_r <= prod[7:0];
          quo_r <= '0;
          cnt_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          low_r <= {low_r[6:0], 1'b0};
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            case (ch_r)
              2'd0: begin
                red_r <= fade_val;
                ch_r <= 2'd1;
                state_r <= S_MUL;
              end
              2'd1: begin
                green_r <= fade_val;
                ch_r <= 2'd2;
                state_r <= S_MUL;
              end
              default: begin
                blue_r <= fade_val;
                cur_r <= {red_r, green_r, fade_val};
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_SINE: begin
          red_r <= sr[15:8];
          green_r <= sg[15:8];
          blue_r <= sb[15:8];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_out_blocks_in, out_valid, in_stall)
  `ASSERT_NXT(a_cmd_no_result, accept && (in_req_type != REQ_TICK), !out_valid)
  `ASSERT_NXT(a_hold_result, out_valid && out_stall,
              out_valid && $stable({red_r, green_r, blue_r}))

endmodule
